// File: hdl/mcopa_pkg.sv
package mcopa_pkg;

  localparam int unsigned ZW = 16;

  localparam logic [2:0] REG_SPOT    = 3'd0;
  localparam logic [2:0] REG_STRIKE  = 3'd1;
  localparam logic [2:0] REG_DRIFT   = 3'd2;
  localparam logic [2:0] REG_VOL     = 3'd3;
  localparam logic [2:0] REG_KIND    = 3'd4;
  localparam logic [2:0] REG_MODE    = 3'd5;
  localparam logic [2:0] REG_OFFSET  = 3'd6;

  localparam logic [1:0] KIND_CALL    = 2'd0;
  localparam logic [1:0] KIND_PUT     = 2'd1;
  localparam logic [1:0] KIND_DIGITAL = 2'd2;

  localparam logic [43:0] LOG2E_Q16 = 44'd94548;
  localparam logic [17:0] POLY_C5   = 18'd87;
  localparam logic [31:0] ONE_Q16   = 32'd65536;
  localparam logic [31:0] I32_MAX   = 32'h7FFF_FFFF;
  localparam logic [62:0] SQ_MAX    = {63{1'b1}};

  typedef struct packed {
    logic [ZW-1:0] z;
    logic          last;
    logic          anti;
    logic          ctrl;
  } mcopa_item_t;

  function automatic logic [17:0] poly_coef(input logic [2:0] idx);
    logic [17:0] c;
    unique case (idx)
      3'd0:    c = 18'd630;
      3'd1:    c = 18'd3638;
      3'd2:    c = 18'd15743;
      3'd3:    c = 18'd45426;
      default: c = 18'd65536;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/mcopa_front.sv
module mcopa_front import mcopa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ZW-1:0]     in_z_i,
  input  logic              in_last_i,
  input  logic [1:0]        kind_i,
  input  logic [1:0]        mode_i,
  output logic              push_o,
  input  logic              full_i,
  output mcopa_item_t       item_o
);

  logic        valid_q, valid_d;
  mcopa_item_t item_q;
  logic        accept;

  assign in_ready_o = !valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = valid_q && !full_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.z    <= in_z_i;
      item_q.last <= in_last_i;
      item_q.anti <= mode_i[0];
      item_q.ctrl <= mode_i[1] && (kind_i == KIND_CALL || kind_i == KIND_PUT);
    end
  end

endmodule

// File: hdl/mcopa_queue.sv
module mcopa_queue import mcopa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  mcopa_item_t item_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output mcopa_item_t item_o
);

  mcopa_item_t mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: hdl/mcopa_back.sv
module mcopa_back import mcopa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  output logic        pop_o,
  input  mcopa_item_t item_i,
  input  logic [31:0] spot_i,
  input  logic [31:0] strike_i,
  input  logic [31:0] drift_i,
  input  logic [31:0] vol_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_payoff_o,
  output logic [63:0] out_sum_o,
  output logic [62:0] out_sq_o,
  output logic        out_last_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_T     = 4'd1;
  localparam logic [3:0] S_X     = 4'd2;
  localparam logic [3:0] S_POLY  = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_ST    = 4'd5;
  localparam logic [3:0] S_PAY   = 4'd6;
  localparam logic [3:0] S_COMB  = 4'd7;
  localparam logic [3:0] S_SQ    = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]  state_q, state_d;
  logic        leg_q, leg_d;
  logic [2:0]  cnt_q, cnt_d;
  mcopa_item_t cur_q;
  logic signed [49:0] t_q;
  logic signed [27:0] y_q;
  logic [17:0] p_q;
  logic [31:0] e_q;
  logic [47:0] st_q;
  logic [31:0] std_q, alt_q;
  logic [31:0] pay_q;
  logic [47:0] sq_q;
  logic [63:0] sum_q, sum_d;
  logic [62:0] sqa_q, sqa_d;
  logic        ov_q, ov_d;
  logic [31:0] opay_q;
  logic [63:0] osum_q;
  logic [62:0] osq_q;
  logic        olast_q;

  logic signed [16:0] z17, zl;
  logic signed [49:0] t_c;
  logic signed [43:0] ym;
  logic signed [11:0] n_c;
  logic [11:0] nn_c;
  logic [15:0] f_c;
  logic [33:0] pf;
  logic [33:0] ev;
  logic [31:0] e_c;
  logic [63:0] stm;
  logic [47:0] k48;
  logic [31:0] leg_c;
  logic [32:0] pair;
  logic [31:0] pa;
  logic signed [34:0] pc;
  logic [31:0] p_c;
  logic [31:0] mag;
  logic [63:0] mm;
  logic signed [64:0] s65;
  logic [63:0] q64;
  logic [63:0] rsum;
  logic [62:0] rsq;
  logic        load;

  assign z17 = {cur_q.z[ZW-1], cur_q.z};
  assign zl  = leg_q ? -z17 : z17;
  assign t_c = ($signed(vol_i) * zl) + $signed({{6{drift_i[31]}}, drift_i, 12'b0});
  assign ym  = $signed(t_q[49:24]) * $signed(LOG2E_Q16);
  assign n_c = y_q[27:16];
  assign nn_c = -n_c;
  assign f_c = y_q[15:0];
  assign pf  = p_q * {2'b0, f_c};
  assign ev  = {16'b0, p_q} << n_c[3:0];
  assign stm = {32'b0, spot_i} * {32'b0, e_q};
  assign k48 = {16'b0, strike_i};

  always_comb begin
    if (n_c >= 12'sd16) begin
      e_c = 32'hFFFF_FFFF;
    end else if (n_c < -12'sd17) begin
      e_c = 32'd0;
    end else if (!n_c[11]) begin
      e_c = (ev[33:32] != 2'b0) ? 32'hFFFF_FFFF : ev[31:0];
    end else begin
      e_c = 32'({14'b0, p_q} >> nn_c[4:0]);
    end
  end

  always_comb begin
    unique case (kind_i)
      KIND_CALL:    leg_c = (st_q > k48) ? ((st_q - k48 > 48'(I32_MAX)) ? I32_MAX
                                            : 32'(st_q - k48)) : 32'd0;
      KIND_PUT:     leg_c = (k48 > st_q) ? ((k48 - st_q > 48'(I32_MAX)) ? I32_MAX
                                            : 32'(k48 - st_q)) : 32'd0;
      KIND_DIGITAL: leg_c = (st_q > k48) ? ONE_Q16 : 32'd0;
      default:      leg_c = 32'd0;
    endcase
  end

  assign pair = {1'b0, std_q} + {1'b0, alt_q};
  assign pa   = cur_q.anti ? pair[32:1] : std_q;

  always_comb begin
    if (cur_q.ctrl) begin
      pc = $signed({3'b0, pa}) - $signed({3'b0, std_q}) + $signed({3'b0, offset_i});
    end else begin
      pc = $signed({3'b0, pa});
    end
    if (pc > $signed({3'b0, I32_MAX})) begin
      p_c = I32_MAX;
    end else if (pc < -$signed({3'b0, I32_MAX}) - 35'sd1) begin
      p_c = 32'h8000_0000;
    end else begin
      p_c = pc[31:0];
    end
  end

  assign mag = pay_q[31] ? -pay_q : pay_q;
  assign mm  = {32'b0, mag} * {32'b0, mag};
  assign s65 = $signed({sum_q[63], sum_q}) + $signed({{33{pay_q[31]}}, pay_q});
  assign q64 = {1'b0, sqa_q} + {16'b0, sq_q};

  always_comb begin
    if (s65[64] != s65[63]) begin
      sum_d = s65[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_d = s65[63:0];
    end
    sqa_d = q64[63] ? SQ_MAX : q64[62:0];
  end

  always_comb begin
    rsum = sum_q;
    rsq  = sqa_q;
    if (cur_q.anti) begin
      if (sum_q[63] != sum_q[62]) begin
        rsum = sum_q[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end else begin
        rsum = {sum_q[62:0], 1'b0};
      end
      rsq = sqa_q[62] ? SQ_MAX : {sqa_q[61:0], 1'b0};
    end
  end

  assign load  = (state_q == S_OUT) && (!ov_q || out_ready_i);
  assign pop_o = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    state_d = state_q;
    leg_d   = leg_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE:  if (!empty_i) begin
        state_d = S_T;
        leg_d   = 1'b0;
      end
      S_T:     state_d = S_X;
      S_X: begin
        state_d = S_POLY;
        cnt_d   = 3'd0;
      end
      S_POLY: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: state_d = S_ST;
      S_ST:    state_d = S_PAY;
      S_PAY: begin
        if (cur_q.anti && !leg_q) begin
          leg_d   = 1'b1;
          state_d = S_T;
        end else begin
          state_d = S_COMB;
        end
      end
      S_COMB:  state_d = S_SQ;
      S_SQ:    state_d = S_ACC;
      S_ACC:   state_d = S_OUT;
      S_OUT: if (load) begin
        ov_d    = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      leg_q   <= 1'b0;
      cnt_q   <= 3'd0;
      ov_q    <= 1'b0;
      sum_q   <= 64'd0;
      sqa_q   <= 63'd0;
    end else begin
      state_q <= state_d;
      leg_q   <= leg_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (state_q == S_ACC) begin
        sum_q <= sum_d;
        sqa_q <= sqa_d;
      end else if (load && cur_q.last) begin
        sum_q <= 64'd0;
        sqa_q <= 63'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
    if (state_q == S_T) begin
      t_q <= t_c;
    end
    if (state_q == S_X) begin
      y_q <= ym[43:16];
      p_q <= POLY_C5;
    end
    if (state_q == S_POLY) begin
      p_q <= poly_coef(cnt_q) + pf[33:16];
    end
    if (state_q == S_SHIFT) begin
      e_q <= e_c;
    end
    if (state_q == S_ST) begin
      st_q <= stm[63:16];
    end
    if (state_q == S_PAY) begin
      if (leg_q) begin
        alt_q <= leg_c;
      end else begin
        std_q <= leg_c;
      end
    end
    if (state_q == S_COMB) begin
      pay_q <= p_c;
    end
    if (state_q == S_SQ) begin
      sq_q <= mm[63:16];
    end
    if (load) begin
      opay_q  <= pay_q;
      osum_q  <= rsum;
      osq_q   <= rsq;
      olast_q <= cur_q.last;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_payoff_o = opay_q;
  assign out_sum_o    = osum_q;
  assign out_sq_o     = osq_q;
  assign out_last_o   = olast_q;

`ifndef SYNTHESIS
  a_poly_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POLY |-> cnt_q <= 3'd4)
    else $error("horner step count out of range");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && cur_q.last |=> sum_q == 64'd0 && sqa_q == 63'd0)
    else $error("accumulators not cleared after last transfer");
  a_leg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMB |-> !std_q[31])
    else $error("leg payoff exceeds signed range");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_T && !leg_q)
    else $error("pop did not start an item");
`endif

endmodule

// File: hdl/monte_carlo_option_payoff_accumulator_unit.sv
// Monte Carlo option payoff accumulator.
// Slave stream: tdata[15:0] is a Q4.12 normal draw, tlast marks the last
// draw of a run. Master stream: one transfer per input transfer carrying
// the item payoff, running sum and running square sum; tlast closes the run.
// Configuration: cfg_valid_i/cfg_ready_o with a 3-bit register index and
// 32-bit data; always ready, write only while the block is idle.
// The back end takes one item at a time into a shared exp/multiply
// sequencer, which evaluates each leg over ten steps (five Horner steps);
// antithetic modes evaluate a second, negated leg for each item.
// A two-entry queue sits between the input register and the sequencer, so
// further input transfers are taken while an item is evaluated.
// Reset clears the accumulators, the queue and the valid flags and loads
// the default registers (spot and strike 100.0, call, no variance reduction).
// A stalled receiver holds the output register; the sequencer then waits,
// the queue fills and tready drops.
module monte_carlo_option_payoff_accumulator_unit import mcopa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // [15:0] normal_sample
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] path_payoff, [95:32] running sum, [158:96] payoff_square_sum, [159] zero
  output logic [159:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [31:0] spot_q, strike_q, drift_q, vol_q, offset_q;
  logic [1:0]  kind_q, mode_q;
  logic        push, full, pop, empty;
  mcopa_item_t fitem, qitem;
  logic [31:0] payoff;
  logic [63:0] sum;
  logic [62:0] sq;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spot_q   <= 32'd6553600;
      strike_q <= 32'd6553600;
      drift_q  <= 32'd0;
      vol_q    <= 32'd0;
      kind_q   <= KIND_CALL;
      mode_q   <= 2'd0;
      offset_q <= 32'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SPOT:   spot_q   <= cfg_data_i;
        REG_STRIKE: strike_q <= cfg_data_i;
        REG_DRIFT:  drift_q  <= cfg_data_i;
        REG_VOL:    vol_q    <= cfg_data_i;
        REG_KIND:   kind_q   <= cfg_data_i[1:0];
        REG_MODE:   mode_q   <= cfg_data_i[1:0];
        REG_OFFSET: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcopa_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_z_i     (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .kind_i     (kind_q),
    .mode_i     (mode_q),
    .push_o     (push),
    .full_i     (full),
    .item_o     (fitem)
  );

  mcopa_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (fitem),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (qitem)
  );

  mcopa_back u_back (
    .clk_i, .rst_ni,
    .empty_i      (empty),
    .pop_o        (pop),
    .item_i       (qitem),
    .spot_i       (spot_q),
    .strike_i     (strike_q),
    .drift_i      (drift_q),
    .vol_i        (vol_q),
    .kind_i       (kind_q),
    .offset_i     (offset_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_payoff_o (payoff),
    .out_sum_o    (sum),
    .out_sq_o     (sq),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, sq, sum, payoff};

endmodule
